[hdl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// While valid waits for ready, the next cycle still shows valid with the same payload.
`define ASSERT_HOLD(label, clk, rst_n, vld, rdy, pay) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(pay))) else $error("hold violated");

// Condition a implies condition b in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (b)) else $error("implication violated");

// Condition a implies condition b in the next cycle; checked through reset.
`define ASSERT_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) \
    (a) |=> (b)) else $error("next-cycle implication violated");

`endif

[hdl/stds_pkg.sv]
`timescale 1ns / 1ps
package stds_pkg;

  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;

  // Result field widths
  localparam int LINE_OUT_W = 20;
  localparam int COL_OUT_W  = 16;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_CASE_BIT = 8'h20;

  localparam int KW_COUNT = 4;

  // Keyword lengths: agent, skill, fun, fn
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd5, 3'd3, 3'd2};

  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{8'h61, 8'h67, 8'h65, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h6B, 8'h69, 8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h75, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef enum logic {
    KIND_KEYWORD  = 1'b0,
    KIND_VARIABLE = 1'b1
  } token_kind_t;

  typedef struct packed {
    logic [LINE_OUT_W-1:0] line_delta;
    logic [COL_OUT_W-1:0]  start_delta;
    logic [COL_OUT_W-1:0]  token_length;
    token_kind_t           token_kind;
  } stds_tok_t;

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    return KW_TEXT[k][idx];
  endfunction

endpackage

[hdl/semantic_token_delta_scanner_unit.sv]
`timescale 1ns / 1ps
// Semantic token scanner: turns a byte stream of document text into delta-encoded
// identifier tokens, one token per finished identifier.
// Input channel: in_valid/in_ready carry one text byte and a last-byte flag per
// transfer. Output channel: out_valid/out_ready carry line delta, start delta,
// length and kind (keyword or variable) of one identifier per transfer.
// Throughput is one byte per cycle while the receiver keeps up: a byte is
// captured in the input register, the scanner logic runs between that register
// and the result register, and the scan state updates in the same cycle. A
// token is offered from the result register after its byte left the input register.
// When the receiver stalls, the result register holds its token and the input
// register holds its byte; in_ready drops once both are occupied and returns in
// the cycle that out_ready rises.
// The byte flagged last closes the document: any open identifier is issued and
// line, column and previous-token state return to their reset values.
// Reset (rst_n low, synchronous) empties both registers and clears the scan state.
module semantic_token_delta_scanner_unit #(
  parameter int LINE_BITS   = stds_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stds_pkg::COLUMN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_doc_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stds_pkg::LINE_OUT_W-1:0]  out_line_delta,
  output logic [stds_pkg::COL_OUT_W-1:0]   out_start_delta,
  output logic [stds_pkg::COL_OUT_W-1:0]   out_token_length,
  output logic                             out_token_kind
);
  import stds_pkg::*;

  // Input register: the byte waiting to be scanned.
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // Result register.
  logic       out_valid_r;
  stds_tok_t  tok_r;

  logic       fire;
  logic       emit;
  stds_tok_t  tok;

  // The held byte is scanned when the result register is free or being emptied.
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  stds_scan #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .text_byte (byte_r),
    .doc_last  (last_r),
    .emit      (emit),
    .tok       (tok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
      last_r <= in_doc_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      tok_r <= tok;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_delta   = tok_r.line_delta;
  assign out_start_delta  = tok_r.start_delta;
  assign out_token_length = tok_r.token_length;
  assign out_token_kind   = tok_r.token_kind;

endmodule

[hdl/stds_scan.sv]
`timescale 1ns / 1ps
module stds_scan #(
  parameter int LINE_BITS   = stds_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stds_pkg::COLUMN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          text_byte,
  input  logic                doc_last,
  output logic                emit,
  output stds_pkg::stds_tok_t tok
);
  import stds_pkg::*;

  localparam int DLW = (LINE_BITS > LINE_OUT_W) ? LINE_BITS : LINE_OUT_W;
  localparam int DCW = (COLUMN_BITS > COL_OUT_W) ? COLUMN_BITS : COL_OUT_W;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

  logic [LINE_BITS-1:0]   line_r, prior_line_r;
  logic [COLUMN_BITS-1:0] col_r, prior_start_r, begin_r, len_r;
  logic                   inside_r;
  logic [KW_COUNT-1:0]    hits_r;

  logic [7:0]             low_b;
  logic                   is_alpha, is_digit, is_start, is_cont, open_nxt;
  logic [COLUMN_BITS-1:0] base_len, len_ext, len_f, begin_f;
  logic [KW_COUNT-1:0]    base_hits, hits_ext, hits_f;
  logic [LINE_BITS-1:0]   dl;
  logic [COLUMN_BITS-1:0] ds;
  logic [DLW-1:0]         dl_w;
  logic [DCW-1:0]         ds_w, len_w;
  logic                   kw_match;

  always_comb begin
    low_b    = text_byte | CH_CASE_BIT;
    is_alpha = (low_b >= CH_LOWER_A) && (low_b <= CH_LOWER_Z);
    is_digit = (text_byte >= CH_DIGIT_0) && (text_byte <= CH_DIGIT_9);
    is_start = is_alpha || (text_byte == CH_UNDERSCORE);
    is_cont  = is_start || is_digit;
    open_nxt = inside_r ? is_cont : is_start;
    emit     = (inside_r && !is_cont) || (doc_last && open_nxt);

    // A fresh identifier starts from an empty prefix that still matches every keyword.
    base_len  = inside_r ? len_r : '0;
    base_hits = inside_r ? hits_r : '1;
    for (int k = 0; k < KW_COUNT; k++) begin
      hits_ext[k] = base_hits[k] && (base_len < COLUMN_BITS'(KW_LEN[k])) &&
                    (kw_char(2'(k), base_len[2:0]) == text_byte);
    end
    len_ext = (base_len == COL_MAX) ? COL_MAX : base_len + 1'b1;

    // Token being finished: the open one as it stands, or including this byte.
    begin_f = inside_r ? begin_r : col_r;
    len_f   = is_cont ? len_ext : base_len;
    hits_f  = is_cont ? hits_ext : base_hits;

    kw_match = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (hits_f[k] && (len_f == COLUMN_BITS'(KW_LEN[k]))) kw_match = 1'b1;
    end

    dl = (line_r >= prior_line_r) ? line_r - prior_line_r : '0;
    if (dl == '0) begin
      ds = (begin_f >= prior_start_r) ? begin_f - prior_start_r : '0;
    end else begin
      ds = begin_f;
    end
    dl_w  = DLW'(dl);
    ds_w  = DCW'(ds);
    len_w = DCW'(len_f);

    tok.line_delta   = (dl_w > DLW'({LINE_OUT_W{1'b1}})) ? '1 : dl_w[LINE_OUT_W-1:0];
    tok.start_delta  = (ds_w > DCW'({COL_OUT_W{1'b1}})) ? '1 : ds_w[COL_OUT_W-1:0];
    tok.token_length = (len_w > DCW'({COL_OUT_W{1'b1}})) ? '1 : len_w[COL_OUT_W-1:0];
    tok.token_kind   = kw_match ? KIND_KEYWORD : KIND_VARIABLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r        <= '0;
      col_r         <= '0;
      prior_line_r  <= '0;
      prior_start_r <= '0;
      inside_r      <= 1'b0;
      begin_r       <= '0;
      len_r         <= '0;
      hits_r        <= '1;
    end else if (step) begin
      if (doc_last) begin
        line_r        <= '0;
        col_r         <= '0;
        prior_line_r  <= '0;
        prior_start_r <= '0;
        inside_r      <= 1'b0;
        begin_r       <= '0;
        len_r         <= '0;
        hits_r        <= '1;
      end else begin
        if (text_byte == CH_NEWLINE) begin
          line_r <= (line_r == LINE_MAX) ? LINE_MAX : line_r + 1'b1;
          col_r  <= '0;
        end else begin
          col_r <= (col_r == COL_MAX) ? COL_MAX : col_r + 1'b1;
        end
        inside_r <= open_nxt;
        if (open_nxt) begin
          begin_r <= begin_f;
          len_r   <= len_ext;
          hits_r  <= hits_ext;
        end
        if (emit) begin
          prior_line_r  <= line_r;
          prior_start_r <= begin_f;
        end
      end
    end
  end

endmodule

[hdl/stds_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stds_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [7:0]                       in_text_byte,
  input logic                             in_doc_last,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [stds_pkg::LINE_OUT_W-1:0]  out_line_delta,
  input logic [stds_pkg::COL_OUT_W-1:0]   out_start_delta,
  input logic [stds_pkg::COL_OUT_W-1:0]   out_token_length,
  input logic                             out_token_kind
);
  import stds_pkg::*;

  logic [LINE_OUT_W+2*COL_OUT_W:0] out_payload;
  logic                            kw_len_ok;
  assign out_payload = {out_line_delta, out_start_delta, out_token_length, out_token_kind};
  assign kw_len_ok   = (out_token_length == 16'd2) || (out_token_length == 16'd3) ||
                       (out_token_length == 16'd5);

  `ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_payload)

  // Keywords are only two, three or five bytes long.
  `ASSERT_IMPLIES(a_kw_len, clk, rst_n, out_valid && (out_token_kind == KIND_KEYWORD), kw_len_ok)

  `ASSERT_IMPLIES(a_len_nonzero, clk, rst_n, out_valid, out_token_length != '0)

  // No result is offered in the cycle after reset.
  `ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

  // With no result waiting, the input side is never refused.
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

endmodule

bind semantic_token_delta_scanner_unit stds_checker u_stds_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import stds_pkg::*;

  localparam logic [7:0] BYTE_NEWLINE    = 8'h0A;
  localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
  localparam logic [7:0] BYTE_CASE_BIT   = 8'h20;
  localparam logic [7:0] BYTE_SPACE      = 8'h20;

  // Cycles with no transfer on either side before the run is declared hung. The
  // longest legal quiet stretch is the deliberate receiver hold-off below.
  localparam int QUIET_LIMIT      = 3000;
  localparam int RANDOM_BYTES     = 800;
  localparam int CALM_TAIL_BYTES  = 150;
  localparam int HOLD_OFF_CYCLES  = 250;
  localparam int DRAIN_CYCLES     = 16;

  // Tracks line, column and the open identifier exactly as the scanner should, and
  // keeps the tokens that are owed by the block in the order they must appear.
  class token_delta_tracker;
    logic [LINE_OUT_W-1:0] line_pos;
    logic [COL_OUT_W-1:0]  col_pos;
    logic [LINE_OUT_W-1:0] last_tok_line;
    logic [COL_OUT_W-1:0]  last_tok_start;
    logic                  in_ident;
    logic [COL_OUT_W-1:0]  ident_start;
    logic [COL_OUT_W-1:0]  ident_len;
    logic [3:0]            kw_alive;
    string                 kw_words[4];
    stds_tok_t             owed_tokens[$];
    int                    errors;

    function new();
      kw_words = '{"agent", "skill", "fun", "fn"};
      errors = 0;
      clear();
    endfunction

    function void clear();
      line_pos = '0;
      col_pos = '0;
      last_tok_line = '0;
      last_tok_start = '0;
      in_ident = 1'b0;
      ident_start = '0;
      ident_len = '0;
      kw_alive = 4'hF;
    endfunction

    function int pending();
      return owed_tokens.size();
    endfunction

    // A keyword stays alive only while every byte so far matches it in order.
    function void grow(logic [7:0] b);
      for (int k = 0; k < 4; k++) begin
        if (kw_alive[k]) begin
          if (!(ident_len < kw_words[k].len() && kw_words[k][ident_len] == b))
            kw_alive[k] = 1'b0;
        end
      end
      if (ident_len != '1) ident_len = ident_len + 1'b1;
    endfunction

    function void close_ident();
      stds_tok_t tok;
      logic [LINE_OUT_W-1:0] dl;
      tok.token_kind = KIND_VARIABLE;
      for (int k = 0; k < 4; k++) begin
        if (kw_alive[k] && ident_len == kw_words[k].len()) tok.token_kind = KIND_KEYWORD;
      end
      dl = (line_pos >= last_tok_line) ? line_pos - last_tok_line : '0;
      tok.line_delta = dl;
      if (dl == '0)
        tok.start_delta = (ident_start >= last_tok_start) ? ident_start - last_tok_start : '0;
      else
        tok.start_delta = ident_start;
      tok.token_length = ident_len;
      owed_tokens.insert(owed_tokens.size(), tok);
      last_tok_line = line_pos;
      last_tok_start = ident_start;
      in_ident = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [7:0] folded;
      logic       letter;
      logic       digit;
      logic       opens;
      folded = b | BYTE_CASE_BIT;
      letter = (folded >= "a") && (folded <= "z");
      digit = (b >= "0") && (b <= "9");
      opens = letter || (b == BYTE_UNDERSCORE);
      if (in_ident && (opens || digit)) begin
        grow(b);
      end else if (in_ident) begin
        close_ident();
      end else if (opens) begin
        in_ident = 1'b1;
        ident_start = col_pos;
        ident_len = '0;
        kw_alive = 4'hF;
        grow(b);
      end
      if (b == BYTE_NEWLINE) begin
        if (line_pos != '1) line_pos = line_pos + 1'b1;
        col_pos = '0;
      end else if (col_pos != '1) begin
        col_pos = col_pos + 1'b1;
      end
      if (last) begin
        if (in_ident) close_ident();
        clear();
      end
    endfunction

    function void match_token(stds_tok_t got);
      stds_tok_t want;
      if (owed_tokens.size() == 0) begin
        $error("unexpected token: line_delta %0d start_delta %0d length %0d kind %0d",
               got.line_delta, got.start_delta, got.token_length, got.token_kind);
        errors++;
        return;
      end
      want = owed_tokens.pop_front();
      if (got.line_delta !== want.line_delta) begin
        $error("line_delta: expected %0d, actual %0d", want.line_delta, got.line_delta);
        errors++;
      end
      if (got.start_delta !== want.start_delta) begin
        $error("start_delta: expected %0d, actual %0d", want.start_delta, got.start_delta);
        errors++;
      end
      if (got.token_length !== want.token_length) begin
        $error("token_length: expected %0d, actual %0d", want.token_length,
               got.token_length);
        errors++;
      end
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, actual %0d", want.token_kind, got.token_kind);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_text_byte;
  logic                  in_doc_last;
  logic                  out_valid;
  logic                  out_ready;
  logic [LINE_OUT_W-1:0] out_line_delta;
  logic [COL_OUT_W-1:0]  out_start_delta;
  logic [COL_OUT_W-1:0]  out_token_length;
  logic                  out_token_kind;

  token_delta_tracker tracker;
  bit                 idling_on;
  bit                 hold_off_req;
  int                 rand_bytes;
  int                 quiet_cycles;

  semantic_token_delta_scanner_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_doc_last      (in_doc_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_delta   (out_line_delta),
    .out_start_delta  (out_start_delta),
    .out_token_length (out_token_length),
    .out_token_kind   (out_token_kind)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offers one byte from a falling edge and holds it until the transfer happens.
  // Valid is only lowered when a gap is wanted, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      in_text_byte = 8'($urandom_range(0, 255));
      in_doc_last = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_text_byte = b;
    in_doc_last = last;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit close_doc);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close_doc && (i == s.len() - 1));
  endtask

  // Appends one byte at the end of a document under construction.
  function automatic void put_byte(ref logic [7:0] doc[$], input logic [7:0] b);
    doc.insert(doc.size(), b);
  endfunction

  // Appends a keyword, a near miss of one, or a random identifier, sometimes after
  // a digit that the scanner has to skip.
  task automatic add_word(ref logic [7:0] doc[$]);
    string kw[4];
    string near[10];
    string picked;
    int    tail;
    kw = '{"agent", "skill", "fun", "fn"};
    near = '{"agen", "ski", "fu", "f", "funn", "fnx", "agent_", "Skill", "FN", "_"};
    picked = "";
    case ($urandom_range(0, 9))
      0, 1, 2, 3: picked = kw[$urandom_range(0, 3)];
      4: picked = near[$urandom_range(0, 9)];
      default: begin
        if ($urandom_range(0, 4) == 0) put_byte(doc, 8'($urandom_range("0", "9")));
        case ($urandom_range(0, 2))
          0: put_byte(doc, 8'($urandom_range("a", "z")));
          1: put_byte(doc, 8'($urandom_range("A", "Z")));
          default: put_byte(doc, BYTE_UNDERSCORE);
        endcase
        tail = $urandom_range(0, 9);
        repeat (tail) begin
          case ($urandom_range(0, 3))
            0: put_byte(doc, 8'($urandom_range("A", "Z")));
            1: put_byte(doc, 8'($urandom_range("0", "9")));
            2: put_byte(doc, BYTE_UNDERSCORE);
            default: put_byte(doc, 8'($urandom_range("a", "z")));
          endcase
        end
      end
    endcase
    for (int i = 0; i < picked.len(); i++) put_byte(doc, picked[i]);
  endtask

  // Most documents are words with separators; one in ten is raw noise. About half
  // of the word documents end inside an identifier.
  task automatic send_random_doc();
    logic [7:0] doc[$];
    string      punct;
    int         words;
    punct = "(){};,.+-=:";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) put_byte(doc, 8'($urandom_range(0, 255)));
    end else begin
      words = $urandom_range(1, 8);
      for (int w = 0; w < words; w++) begin
        add_word(doc);
        if (w < words - 1 || $urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 7))
            0, 1, 2: put_byte(doc, BYTE_SPACE);
            3: put_byte(doc, BYTE_NEWLINE);
            4: repeat ($urandom_range(2, 4)) put_byte(doc, BYTE_NEWLINE);
            5: put_byte(doc, punct[$urandom_range(0, punct.len() - 1)]);
            6: put_byte(doc, 8'($urandom_range(128, 255)));
            default: put_byte(doc, 8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
    for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
    rand_bytes += doc.size();
  endtask

  // Receiver side: ready is decided at each falling edge. Besides short random
  // stalls it honours one long hold-off request so that both internal registers
  // fill and the scanner has to refuse input.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Every token transfer is checked against the oldest one still owed.
  always @(posedge clk) begin
    stds_tok_t got;
    if (rst_n && out_valid && out_ready) begin
      got.line_delta = out_line_delta;
      got.start_delta = out_start_delta;
      got.token_length = out_token_length;
      got.token_kind = token_kind_t'(out_token_kind);
      tracker.match_token(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    bit held;
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_doc_last = 1'b0;
    out_ready = 1'b0;
    idling_on = 1'b1;
    hold_off_req = 1'b0;
    rand_bytes = 0;
    quiet_cycles = 0;
    held = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed documents: the four keywords, two on each side of a newline, with
    // the last one closed by the end of the document.
    send_text("agent skill\nfun fn", 1'b1);
    // A leading digit is skipped, case matters for keywords, bytes above 127 are
    // separators, and an identifier longer than any keyword is a variable.
    send_text("1ab _x9 Fn", 1'b0);
    send_byte(8'hE1, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("agents", 1'b1);
    // A document with no identifier at all, then a one-byte identifier document.
    send_byte(".", 1'b1);
    send_byte("z", 1'b1);
    // The final byte is a newline that closes the identifier before the reset.
    send_byte(8'hFF, 1'b0);
    send_text("fn\n", 1'b1);

    while (rand_bytes < RANDOM_BYTES) begin
      if (rand_bytes >= RANDOM_BYTES - CALM_TAIL_BYTES) idling_on = 1'b0;
      if (!held && rand_bytes >= 250) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      send_random_doc();
    end

    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
